// ===== rtl/vaft_pkg.sv =====
// shared types, angle constants and arctangent table for the vector angle pipeline
// no dependencies; imported by every module of the block
`default_nettype none
package vaft_pkg;

    localparam int VAFT_COORD_WIDTH  = 16;
    localparam int VAFT_CORDIC_STEPS = 16;

    // cordic datapath widths: coordinates scaled to 2^47, growth stays below 2^49
    localparam int XW        = 51;
    localparam int ZW        = 27;
    localparam int SCALE_TOP = 48;
    localparam int TABLE_LEN = 24;
    localparam int ANG_W     = 16;

    // angles in unsigned q3.13 radians
    localparam logic [ANG_W-1:0] ANG_ZERO          = 16'd0;
    localparam logic [ANG_W-1:0] ANG_HALF_PI       = 16'd12868;
    localparam logic [ANG_W-1:0] ANG_PI            = 16'd25736;
    localparam logic [ANG_W-1:0] ANG_THREE_HALF_PI = 16'd38604;
    localparam logic [ANG_W-1:0] ANG_TWO_PI        = 16'd51472;
    localparam logic [ANG_W-1:0] ANG_MAX           = 16'd51471;

    // pi/2 in q.24
    localparam logic signed [ZW-1:0] ACC_HALF_PI = 27'sd26353589;

    // atan(2^-i) in q.24, rounded to nearest
    localparam logic signed [ZW-1:0] ATAN_TABLE [TABLE_LEN] = '{
        27'sd13176795, 27'sd7778716, 27'sd4110060, 27'sd2086331,
        27'sd1047214,  27'sd524117,  27'sd262123,  27'sd131069,
        27'sd65536,    27'sd32768,   27'sd16384,   27'sd8192,
        27'sd4096,     27'sd2048,    27'sd1024,    27'sd512,
        27'sd256,      27'sd128,     27'sd64,      27'sd32,
        27'sd16,       27'sd8,       27'sd4,       27'sd2
    };

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } quad_t;

    // per-word side information carried alongside the cordic registers
    typedef struct packed {
        logic              fixed;        // zero vector or on an axis
        logic [ANG_W-1:0]  fixed_angle;
        quad_t             quad;
    } vaft_ctx_t;

endpackage
`default_nettype wire

// ===== rtl/vaft_prep.sv =====
// input stage: absolute values, axis and quadrant detection, magnitude scaling
// depends on vaft_pkg
`default_nettype none
module vaft_prep
    import vaft_pkg::*;
#(
    parameter int COORD_WIDTH = VAFT_COORD_WIDTH
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic signed [COORD_WIDTH-1:0] re,
    input  wire logic signed [COORD_WIDTH-1:0] im,
    output logic                               valid_reg,
    output logic signed [XW-1:0]               x_reg,
    output logic signed [XW-1:0]               y_reg,
    output vaft_ctx_t                          ctx_reg
);

    localparam int SH = SCALE_TOP - COORD_WIDTH;

    logic [COORD_WIDTH-1:0] ax;
    logic [COORD_WIDTH-1:0] ay;
    logic signed [XW-1:0]   x_next;
    logic signed [XW-1:0]   y_next;
    vaft_ctx_t              ctx_next;
    logic                   re_zero;
    logic                   im_zero;

    // magnitude in coord_width bits unsigned covers the most negative code too
    assign ax = re[COORD_WIDTH-1] ? COORD_WIDTH'(-re) : COORD_WIDTH'(re);
    assign ay = im[COORD_WIDTH-1] ? COORD_WIDTH'(-im) : COORD_WIDTH'(im);

    assign x_next = $signed({{(XW-COORD_WIDTH){1'b0}}, ax} << SH);
    assign y_next = $signed({{(XW-COORD_WIDTH){1'b0}}, ay} << SH);

    assign re_zero = (re == '0);
    assign im_zero = (im == '0);

    always_comb
    begin
        ctx_next.fixed       = re_zero || im_zero;
        ctx_next.fixed_angle = ANG_ZERO;
        ctx_next.quad        = QUAD_I;
        if (re_zero && im_zero)
        begin
            ctx_next.fixed_angle = ANG_ZERO;
        end
        else if (re_zero)
        begin
            ctx_next.fixed_angle = im[COORD_WIDTH-1] ? ANG_THREE_HALF_PI : ANG_HALF_PI;
        end
        else if (im_zero)
        begin
            ctx_next.fixed_angle = re[COORD_WIDTH-1] ? ANG_PI : ANG_ZERO;
        end
        case ({re[COORD_WIDTH-1], im[COORD_WIDTH-1]})
            2'b00:   ctx_next.quad = QUAD_I;
            2'b10:   ctx_next.quad = QUAD_II;
            2'b11:   ctx_next.quad = QUAD_III;
            default: ctx_next.quad = QUAD_IV;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            ctx_reg <= ctx_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/vaft_cordic_stage.sv =====
// one vectoring-mode cordic rotation with its pipeline register
// depends on vaft_pkg
`default_nettype none
module vaft_cordic_stage
    import vaft_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 valid_in,
    input  wire logic signed [XW-1:0] x_in,
    input  wire logic signed [XW-1:0] y_in,
    input  wire logic signed [ZW-1:0] z_in,
    input  wire vaft_ctx_t            ctx_in,
    output logic                      valid_reg,
    output logic signed [XW-1:0]      x_reg,
    output logic signed [XW-1:0]      y_reg,
    output logic signed [ZW-1:0]      z_reg,
    output vaft_ctx_t                 ctx_reg
);

    localparam logic signed [ZW-1:0] ATAN_I = ATAN_TABLE[IDX];

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic                 y_pos;
    logic signed [XW-1:0] x_next;
    logic signed [XW-1:0] y_next;
    logic signed [ZW-1:0] z_next;

    assign dx    = y_in >>> IDX;
    assign dy    = x_in >>> IDX;
    assign y_pos = !y_in[XW-1] && (y_in != '0);

    // rotate toward the x axis, y equal to zero goes the negative way
    assign x_next = y_pos ? x_in + dx : x_in - dx;
    assign y_next = y_pos ? y_in - dy : y_in + dy;
    assign z_next = y_pos ? z_in + ATAN_I : z_in - ATAN_I;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            ctx_reg <= ctx_in;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/vaft_finish.sv =====
// final angle: clamp and round the accumulator, fold in the quadrant
// depends on vaft_pkg
`default_nettype none
module vaft_finish
    import vaft_pkg::*;
(
    input  wire logic signed [ZW-1:0] z,
    input  wire vaft_ctx_t            ctx,
    output logic [ANG_W-1:0]          angle
);

    localparam int CW_Z = ZW - 2;

    logic [CW_Z-1:0]   z_clamped;
    logic [CW_Z:0]     z_round;
    logic [ANG_W-1:0]  a_raw;
    logic [ANG_W-1:0]  a;
    logic [ANG_W-1:0]  quad_angle;

    always_comb
    begin
        if (z[ZW-1])
        begin
            z_clamped = '0;
        end
        else if (z > ACC_HALF_PI)
        begin
            z_clamped = ACC_HALF_PI[CW_Z-1:0];
        end
        else
        begin
            z_clamped = z[CW_Z-1:0];
        end
    end

    // round half up from q.24 to q3.13
    assign z_round = {1'b0, z_clamped} + (CW_Z+1)'(1024);
    assign a_raw   = ANG_W'(z_round[CW_Z:11]);
    assign a       = (a_raw > ANG_HALF_PI) ? ANG_HALF_PI : a_raw;

    always_comb
    begin
        case (ctx.quad)
            QUAD_I:   quad_angle = a;
            QUAD_II:  quad_angle = ANG_PI - a;
            QUAD_III: quad_angle = ANG_PI + a;
            QUAD_IV:  quad_angle = ANG_TWO_PI - a;
            default:  quad_angle = a;
        endcase
        if (ctx.fixed)
        begin
            angle = ctx.fixed_angle;
        end
        else if (quad_angle > ANG_MAX)
        begin
            angle = ANG_MAX;
        end
        else
        begin
            angle = quad_angle;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/vaft_skid.sv =====
// output register with one skid entry; stalls the pipeline from a register
// depends on vaft_pkg
`default_nettype none
module vaft_skid
    import vaft_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [ANG_W-1:0] in_angle,
    output logic                  advance,
    output logic                  out_valid_reg,
    input  wire logic             out_ready,
    output logic [ANG_W-1:0]      out_angle_reg
);

    logic             skid_valid_reg;
    logic [ANG_W-1:0] skid_angle_reg;
    logic             pop;
    logic             push;

    // pipeline moves only while the skid entry is free
    assign advance = !skid_valid_reg;
    assign pop     = out_valid_reg && out_ready;
    assign push    = advance && in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_angle_reg <= skid_angle_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_angle_reg <= in_angle;
            end
            else
            begin
                out_angle_reg <= in_angle;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/vector_angle_full_turn_top.sv =====
// Vector angle over a full turn. Each input word carries one vector (real and imaginary
// part, two's complement) and yields one output word with its angle from the positive
// real axis in unsigned q3.13 radians, 0 up to 51471 (just below 2*pi). The zero vector
// reads 0, points on an axis give the exact codes for 0, pi/2, pi and 3*pi/2, all other
// points go through a vectoring cordic on the magnitudes and the quadrant then maps the
// first-quadrant arctangent onto the full turn. The datapath is a fully unrolled cordic:
// one input register, one register per rotation (CORDIC_STEPS of them, at most 24), then
// the rounding and quadrant fold into the output register. A new word is taken every
// clock while s_tready is high. A single skid entry behind the output register takes
// the word that arrives while the output word is refused, and the pipeline stops while
// it is full; s_tready comes straight from a flip-flop. Only the low 2*COORD_WIDTH bits
// of tdata are used, as two signed COORD_WIDTH-bit parts.
// depends on vaft_pkg, vaft_prep, vaft_cordic_stage, vaft_finish, vaft_skid
`default_nettype none
module vector_angle_full_turn_top
    import vaft_pkg::*;
#(
    parameter int COORD_WIDTH  = VAFT_COORD_WIDTH,
    parameter int CORDIC_STEPS = VAFT_CORDIC_STEPS
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // input word
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // real_part [COORD_WIDTH-1:0], imag_part above it, zero fill to bytes
    input  wire logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    // output word
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // angle [15:0]
    output logic [ANG_W-1:0]             m_tdata
);

    localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

    logic                          advance;
    logic signed [COORD_WIDTH-1:0] re;
    logic signed [COORD_WIDTH-1:0] im;

    // pipeline rank k feeds rotation k; the last rotation keeps z but not x and y
    logic                 valid_pipe [STEPS+1];
    logic signed [XW-1:0] x_pipe     [STEPS];
    logic signed [XW-1:0] y_pipe     [STEPS];
    logic signed [ZW-1:0] z_pipe     [STEPS+1];
    vaft_ctx_t            ctx_pipe   [STEPS+1];

    logic [ANG_W-1:0]     angle;

    assign s_tready = advance;
    assign re       = $signed(s_tdata[COORD_WIDTH-1:0]);
    assign im       = $signed(s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);

    vaft_prep #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (s_tvalid),
        .re        (re),
        .im        (im),
        .valid_reg (valid_pipe[0]),
        .x_reg     (x_pipe[0]),
        .y_reg     (y_pipe[0]),
        .ctx_reg   (ctx_pipe[0])
    );

    // accumulator starts at zero
    assign z_pipe[0] = '0;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_rot
        if (k < STEPS - 1)
        begin : g_mid
            vaft_cordic_stage #(
                .IDX (k)
            ) u_rot (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (advance),
                .valid_in  (valid_pipe[k]),
                .x_in      (x_pipe[k]),
                .y_in      (y_pipe[k]),
                .z_in      (z_pipe[k]),
                .ctx_in    (ctx_pipe[k]),
                .valid_reg (valid_pipe[k+1]),
                .x_reg     (x_pipe[k+1]),
                .y_reg     (y_pipe[k+1]),
                .z_reg     (z_pipe[k+1]),
                .ctx_reg   (ctx_pipe[k+1])
            );
        end
        else
        begin : g_last
            vaft_cordic_stage #(
                .IDX (k)
            ) u_rot (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (advance),
                .valid_in  (valid_pipe[k]),
                .x_in      (x_pipe[k]),
                .y_in      (y_pipe[k]),
                .z_in      (z_pipe[k]),
                .ctx_in    (ctx_pipe[k]),
                .valid_reg (valid_pipe[k+1]),
                .x_reg     (),
                .y_reg     (),
                .z_reg     (z_pipe[k+1]),
                .ctx_reg   (ctx_pipe[k+1])
            );
        end
    end

    // rounding and quadrant fold
    vaft_finish u_finish (
        .z     (z_pipe[STEPS]),
        .ctx   (ctx_pipe[STEPS]),
        .angle (angle)
    );

    // output register plus skid entry
    vaft_skid u_skid (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (valid_pipe[STEPS]),
        .in_angle      (angle),
        .advance       (advance),
        .out_valid_reg (m_tvalid),
        .out_ready     (m_tready),
        .out_angle_reg (m_tdata)
    );

endmodule
`default_nettype wire

// ===== rtl/vaft_checker.sv =====
// port-level checks for the vector angle block, bound to the top level
// depends on vaft_pkg and vector_angle_full_turn_top
`default_nettype none
module vaft_checker
    import vaft_pkg::*;
#(
    parameter int COORD_WIDTH = VAFT_COORD_WIDTH
)
(
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 s_tvalid,
    input wire logic                                 s_tready,
    input wire logic [((2*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
    input wire logic                                 m_tvalid,
    input wire logic                                 m_tready,
    input wire logic [ANG_W-1:0]                     m_tdata
);

    // a held output word keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // an offered input word stays put until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input word changed while stalled");

    // angle stays below a full turn
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata <= ANG_MAX)
        else $error("angle at or above 2*pi");

    // input back-pressure only while an output word is waiting
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no output word pending");

    // input stall begins only after a refused output word
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

endmodule

bind vector_angle_full_turn_top vaft_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_vaft_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
